@@ sv/gam_pkg.sv @@
package gam_pkg;

   localparam int GYRO_BITS_DEF = 16;

   // configuration register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_SENSITIVITY = 3'd0;
   localparam logic [2:0] REG_DEAD_ZONE   = 3'd1;
   localparam logic [2:0] REG_ALPHA       = 3'd2;
   localparam logic [2:0] REG_STILL_THR   = 3'd3;
   localparam logic [2:0] REG_CALIB_CNT   = 3'd4;
   localparam logic [2:0] REG_HOLD_MS     = 3'd5;

   localparam logic [9:0]  SENS_RST   = 10'd184;
   localparam logic [11:0] DZ_RST     = 12'd192;
   localparam logic [8:0]  ALPHA_RST  = 9'd61;
   localparam logic [14:0] THR_RST    = 15'd1024;
   localparam logic [9:0]  CALIB_RST  = 10'd100;
   localparam logic [15:0] HOLD_RST   = 16'd120;

   localparam logic [8:0]  ALPHA_MAX  = 9'd256;
   localparam logic [9:0]  COUNT_MAX  = 10'd1023;

   // clutch codes
   localparam logic [1:0] CLUTCH_IDLE   = 2'd0;
   localparam logic [1:0] CLUTCH_ARMING = 2'd1;
   localparam logic [1:0] CLUTCH_ACTIVE = 2'd2;

   localparam int FILTER_SHIFT = 8;
   localparam int CARRY_SHIFT  = 17;
   localparam int STEP_MAX     = 127;
   localparam int CARRY_MAX    = 1023 * 131072;
   localparam int CARRY_W      = 28;
   localparam int SUM_W        = 32;

   // serial divider sizes: |sum| + count/2 over the still count
   localparam int DIV_NUM_BITS = 33;
   localparam int DIV_DEN_BITS = 10;

   typedef struct packed {
      logic                    done;
      logic [DIV_NUM_BITS-1:0] quotient;
   } div_result_type;

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_SQX    = 14'b00000000000010,
      S_SQY    = 14'b00000000000100,
      S_SQZ    = 14'b00000000001000,
      S_THR    = 14'b00000000010000,
      S_STILL  = 14'b00000000100000,
      S_DIVX   = 14'b00000001000000,
      S_WAITX  = 14'b00000010000000,
      S_WAITZ  = 14'b00000100000000,
      S_CLUTCH = 14'b00001000000000,
      S_AXF    = 14'b00010000000000,
      S_AXU    = 14'b00100000000000,
      S_AXC    = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

endpackage

@@ sv/gam_mul.sv @@
module gam_mul import gam_pkg::*; #(
   parameter int A_W = 33,
   parameter int B_W = 17
) (
   input  logic                        clock,
   input  logic signed [A_W-1:0]       mul_a,
   input  logic signed [B_W-1:0]       mul_b,
   output logic signed [A_W+B_W-1:0]   product
);

   logic signed [A_W+B_W-1:0] product_ff;

   // one registered signed product per cycle
   always_ff @(posedge clock) begin
      product_ff <= mul_a * mul_b;
   end

   assign product = product_ff;

endmodule

@@ sv/gam_div.sv @@
module gam_div import gam_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIV_NUM_BITS-1:0] dividend,
   input  logic [DIV_DEN_BITS-1:0] divisor,
   output div_result_type          result
);

   localparam int CNT_W = $clog2(DIV_NUM_BITS + 1);

   logic [DIV_NUM_BITS-1:0] quo_ff, quo_in;
   logic [DIV_DEN_BITS-1:0] rem_ff, rem_in;
   logic [DIV_DEN_BITS-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_DEN_BITS:0]   trial;
   logic                    fits;

   // restoring divide, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[DIV_NUM_BITS-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         quo_in = {quo_ff[DIV_NUM_BITS-2:0], fits};
         rem_in = fits ? DIV_DEN_BITS'(trial - {1'b0, dsr_ff}) : trial[DIV_DEN_BITS-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIV_NUM_BITS);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

@@ sv/gyro_air_mouse_motion.sv @@
// Gyro air-mouse pointer. Each req transfer carries one gyro sample (x pitch, y roll,
// z yaw, in 1/128 dps), the touch and link levels and a millisecond timestamp; each
// produces exactly one rsp transfer with the cursor steps, clutch state, calibration
// flag and a send-report strobe. Until calibrated, consecutive still samples are
// counted and x/z summed; at calib_samples the rounded averages become the bias.
// A touch clutch goes idle, arming, then active after hold_time_ms once calibrated;
// a link drop forces idle until the touch is released and pressed again. While
// active, yaw and pitch minus bias go through a dead zone, a first-order smoother and
// sensitivity scaling, then are rounded with a carried remainder and clamped to
// +-127. All products run through one registered multiplier under a sequencer;
// the block stalls req while one sample is in work. Before calibration a sample
// goes through three squares and the threshold square; after calibration it goes
// straight to the clutch step. An active sample adds, per axis, a smoother product,
// a scaling product and a carry step. The sample that fixes the bias adds a divider
// start and two serial divides, x then z. A stalled result holds the sequencer until
// it is taken. Configuration is an APB-style port at byte addresses 0,4,..,20 and
// must be written while idle.
module gyro_air_mouse_motion import gam_pkg::*; #(
   parameter int GYRO_BITS = GYRO_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // sample channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [GYRO_BITS-1:0] req_gyro_x,
   input  logic signed [GYRO_BITS-1:0] req_gyro_y,
   input  logic signed [GYRO_BITS-1:0] req_gyro_z,
   input  logic                        req_touching,
   input  logic                        req_link_up,
   input  logic [31:0]                 req_time_ms,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [7:0]           rsp_delta_x,
   output logic signed [7:0]           rsp_delta_y,
   output logic [1:0]                  rsp_clutch,
   output logic                        rsp_is_calibrated,
   output logic                        rsp_send_report,
   // configuration
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [4:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   // widths: bias, rate after bias, multiplier operands, product
   localparam int GW = GYRO_BITS;
   localparam int BW = GW + 1;
   localparam int RW = GW + 2;
   localparam int MA = (GW + 11 > 33) ? GW + 11 : 33;
   localparam int MB = (GW + 1 > 16) ? GW + 1 : 16;
   localparam int PW = MA + MB;

   localparam logic signed [PW-1:0] S32_MAX_P = PW'(2147483647);
   localparam logic signed [PW-1:0] S32_MIN_P = -S32_MAX_P - PW'(1);
   localparam logic signed [PW-1:0] STEP_MAX_P  = PW'(STEP_MAX);
   localparam logic signed [PW-1:0] CARRY_MAX_P = PW'(CARRY_MAX);

   // round half away from zero of n / 2^sh
   function automatic logic signed [PW-1:0] rnd_sh(input logic signed [PW-1:0] n,
                                                   input int unsigned sh);
      logic [PW-1:0] mag;
      logic [PW-1:0] q;
      mag = n[PW-1] ? PW'(-n) : PW'(n);
      q = (mag + (PW'(1) << (sh - 1))) >> sh;
      rnd_sh = n[PW-1] ? -signed'(q) : signed'(q);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] n);
      if (n > S32_MAX_P) begin
         sat32 = 32'sh7FFFFFFF;
      end else if (n < S32_MIN_P) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = n[31:0];
      end
   endfunction

   // ---------------- configuration registers ----------------
   logic [9:0]  sens_ff, sens_in;
   logic [11:0] dz_ff, dz_in;
   logic [8:0]  alpha_ff, alpha_in;
   logic [14:0] thr_ff, thr_in;
   logic [9:0]  calib_ff, calib_in;
   logic [15:0] hold_ff, hold_in;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      sens_in  = sens_ff;
      dz_in    = dz_ff;
      alpha_in = alpha_ff;
      thr_in   = thr_ff;
      calib_in = calib_ff;
      hold_in  = hold_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SENSITIVITY: sens_in  = csr_pwdata[9:0];
            REG_DEAD_ZONE:   dz_in    = csr_pwdata[11:0];
            REG_ALPHA:       alpha_in = csr_pwdata[8:0];
            REG_STILL_THR:   thr_in   = csr_pwdata[14:0];
            REG_CALIB_CNT:   calib_in = csr_pwdata[9:0];
            REG_HOLD_MS:     hold_in  = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SENSITIVITY: csr_prdata = 32'(sens_ff);
         REG_DEAD_ZONE:   csr_prdata = 32'(dz_ff);
         REG_ALPHA:       csr_prdata = 32'(alpha_ff);
         REG_STILL_THR:   csr_prdata = 32'(thr_ff);
         REG_CALIB_CNT:   csr_prdata = 32'(calib_ff);
         REG_HOLD_MS:     csr_prdata = 32'(hold_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer state ----------------
   state_type state_ff, state_in;

   // captured sample
   logic signed [GW-1:0] gx_ff, gx_in, gy_ff, gy_in, gz_ff, gz_in;
   logic                 touch_ff, touch_in, link_ff, link_in;
   logic [31:0]          time_ff, time_in;

   // persistent state
   logic                 cal_ff, cal_in;
   logic [9:0]           cnt_ff, cnt_in;
   logic [SUM_W-1:0]     sum_x_ff, sum_x_in, sum_z_ff, sum_z_in;
   logic signed [BW-1:0] bias_x_ff, bias_x_in, bias_z_ff, bias_z_in;
   logic [1:0]           clutch_ff, clutch_in;
   logic                 prior_touch_ff, prior_touch_in;
   logic                 prior_link_ff, prior_link_in;
   logic [31:0]          touch_start_ff, touch_start_in;
   logic signed [31:0]        f_ff [2];
   logic signed [31:0]        f_in [2];
   logic signed [CARRY_W-1:0] carry_ff [2];
   logic signed [CARRY_W-1:0] carry_in [2];

   // working registers
   logic [PW-1:0]   mag_ff, mag_in;
   logic            axis_ff, axis_in;
   logic signed [7:0] dx_ff, dx_in, dy_ff, dy_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [7:0] rsp_dx_ff, rsp_dx_in, rsp_dy_ff, rsp_dy_in;
   logic [1:0]        rsp_clutch_ff, rsp_clutch_in;
   logic              rsp_cal_ff, rsp_cal_in, rsp_send_ff, rsp_send_in;

   // ---------------- shared multiplier ----------------
   logic signed [MA-1:0] mul_a;
   logic signed [MB-1:0] mul_b;
   logic signed [PW-1:0] prod;
   logic [PW-1:0]        prod_u;

   gam_mul #(.A_W(MA), .B_W(MB)) u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (prod)
   );

   assign prod_u = prod;

   // ---------------- serial divider for the bias ----------------
   logic                    div_start;
   logic [DIV_NUM_BITS-1:0] div_dividend;
   logic [DIV_DEN_BITS-1:0] div_divisor;
   div_result_type          div_res;

   gam_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   // ---------------- calibration datapath ----------------
   logic                    still_ok;
   logic [SUM_W:0]          sum_x_add, sum_z_add;
   logic [SUM_W-1:0]        sum_x_sat, sum_z_sat;
   logic [9:0]              cnt_new, need;
   logic                    fix_bias;
   logic [DIV_NUM_BITS-1:0] sum_x_w, sum_z_w, abs_x, abs_z, half_cnt;
   logic [DIV_NUM_BITS-1:0] bias_q;
   logic [DIV_NUM_BITS-1:0] bias_x_full, bias_z_full;

   assign still_ok  = mag_ff <= prod_u;      // prod holds threshold squared here
   assign sum_x_add = {sum_x_ff[SUM_W-1], sum_x_ff} + (SUM_W+1)'(gx_ff);
   assign sum_z_add = {sum_z_ff[SUM_W-1], sum_z_ff} + (SUM_W+1)'(gz_ff);
   assign sum_x_sat = (sum_x_add[SUM_W] != sum_x_add[SUM_W-1]) ?
                      {sum_x_add[SUM_W], {(SUM_W-1){~sum_x_add[SUM_W]}}} :
                      sum_x_add[SUM_W-1:0];
   assign sum_z_sat = (sum_z_add[SUM_W] != sum_z_add[SUM_W-1]) ?
                      {sum_z_add[SUM_W], {(SUM_W-1){~sum_z_add[SUM_W]}}} :
                      sum_z_add[SUM_W-1:0];
   assign cnt_new   = !still_ok ? '0 : ((cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 10'd1);
   assign need      = (calib_ff == '0) ? 10'd1 : calib_ff;
   assign fix_bias  = cnt_new >= need;

   assign sum_x_w  = {{(DIV_NUM_BITS-SUM_W){sum_x_ff[SUM_W-1]}}, sum_x_ff};
   assign sum_z_w  = {{(DIV_NUM_BITS-SUM_W){sum_z_ff[SUM_W-1]}}, sum_z_ff};
   assign abs_x    = sum_x_ff[SUM_W-1] ? -sum_x_w : sum_x_w;
   assign abs_z    = sum_z_ff[SUM_W-1] ? -sum_z_w : sum_z_w;
   assign half_cnt = DIV_NUM_BITS'(cnt_ff >> 1);
   assign bias_q   = div_res.quotient;
   assign bias_x_full = sum_x_ff[SUM_W-1] ? -bias_q : bias_q;
   assign bias_z_full = sum_z_ff[SUM_W-1] ? -bias_q : bias_q;

   // ---------------- clutch ----------------
   logic        press, release_t, go_active, clear_motion, run_axes;
   logic [1:0]  clutch_a, clutch_b;
   logic [31:0] start_eff, held_ms;

   assign press     = touch_ff & ~prior_touch_ff;
   assign release_t = ~touch_ff & prior_touch_ff;
   assign clutch_a  = press ? CLUTCH_ARMING : (release_t ? CLUTCH_IDLE : clutch_ff);
   assign start_eff = press ? time_ff : touch_start_ff;
   assign held_ms   = time_ff - start_eff;
   assign go_active = touch_ff && (clutch_a == CLUTCH_ARMING) && cal_ff &&
                      (held_ms >= {16'd0, hold_ff});
   assign clutch_b  = go_active ? CLUTCH_ACTIVE : clutch_a;
   assign clear_motion = press | release_t | go_active;
   assign run_axes  = touch_ff && (clutch_b == CLUTCH_ACTIVE);

   // ---------------- axis datapath (yaw first, then pitch) ----------------
   logic signed [RW-1:0]      rate, dz_s, dead_v;
   logic signed [MA-1:0]      target, diff;
   logic signed [31:0]        f_cur, f_new;
   logic signed [CARRY_W-1:0] carry_cur, carry_new;
   logic [8:0]                alpha_eff;
   logic signed [PW-1:0]      prod_rnd, f_sum, total, step_full, rem;
   logic signed [7:0]         step;

   assign rate = axis_ff ? (RW'(gx_ff) - RW'(bias_x_ff)) : (RW'(gz_ff) - RW'(bias_z_ff));
   assign dz_s = signed'(RW'(dz_ff));
   assign dead_v = (rate <= dz_s && rate >= -dz_s) ? '0 :
                   ((rate > 0) ? rate - dz_s : rate + dz_s);
   assign target = MA'(dead_v) <<< FILTER_SHIFT;
   assign f_cur  = f_ff[axis_ff];
   assign carry_cur = carry_ff[axis_ff];
   assign diff   = target - MA'(f_cur);
   assign alpha_eff = (alpha_ff > ALPHA_MAX) ? ALPHA_MAX : alpha_ff;

   // same rounding serves the smoother step and the scaled value
   assign prod_rnd = rnd_sh(prod, FILTER_SHIFT);
   assign f_sum    = PW'(f_cur) + prod_rnd;
   assign f_new    = sat32(f_sum);

   assign total     = prod_rnd + PW'(carry_cur);
   assign step_full = rnd_sh(total, CARRY_SHIFT);
   assign step = (step_full > STEP_MAX_P) ? 8'sd127 :
                 ((step_full < -STEP_MAX_P) ? -8'sd127 : step_full[7:0]);
   assign rem  = total - (PW'(step) <<< CARRY_SHIFT);
   assign carry_new = (rem > CARRY_MAX_P) ? CARRY_W'(CARRY_MAX_P) :
                      ((rem < -CARRY_MAX_P) ? CARRY_W'(-CARRY_MAX_P) : rem[CARRY_W-1:0]);

   // ---------------- sequencer ----------------
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      gx_in          = gx_ff;
      gy_in          = gy_ff;
      gz_in          = gz_ff;
      touch_in       = touch_ff;
      link_in        = link_ff;
      time_in        = time_ff;
      cal_in         = cal_ff;
      cnt_in         = cnt_ff;
      sum_x_in       = sum_x_ff;
      sum_z_in       = sum_z_ff;
      bias_x_in      = bias_x_ff;
      bias_z_in      = bias_z_ff;
      clutch_in      = clutch_ff;
      prior_touch_in = prior_touch_ff;
      prior_link_in  = prior_link_ff;
      touch_start_in = touch_start_ff;
      f_in           = f_ff;
      carry_in       = carry_ff;
      mag_in         = mag_ff;
      axis_in        = axis_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      rsp_dx_in      = rsp_dx_ff;
      rsp_dy_in      = rsp_dy_ff;
      rsp_clutch_in  = rsp_clutch_ff;
      rsp_cal_in     = rsp_cal_ff;
      rsp_send_in    = rsp_send_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      mul_a          = '0;
      mul_b          = '0;
      div_start      = 1'b0;
      div_dividend   = abs_x + half_cnt;
      div_divisor    = cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               gx_in    = req_gyro_x;
               gy_in    = req_gyro_y;
               gz_in    = req_gyro_z;
               touch_in = req_touching;
               link_in  = req_link_up;
               time_in  = req_time_ms;
               // link drop forces idle before anything else
               if (prior_link_ff && !req_link_up) begin
                  clutch_in = CLUTCH_IDLE;
               end
               prior_link_in = req_link_up;
               state_in = cal_ff ? S_CLUTCH : S_SQX;
            end
         end
         S_SQX: begin
            mul_a    = MA'(gx_ff);
            mul_b    = MB'(gx_ff);
            state_in = S_SQY;
         end
         S_SQY: begin
            mag_in   = prod_u;
            mul_a    = MA'(gy_ff);
            mul_b    = MB'(gy_ff);
            state_in = S_SQZ;
         end
         S_SQZ: begin
            mag_in   = mag_ff + prod_u;
            mul_a    = MA'(gz_ff);
            mul_b    = MB'(gz_ff);
            state_in = S_THR;
         end
         S_THR: begin
            mag_in   = mag_ff + prod_u;
            mul_a    = signed'(MA'(thr_ff));
            mul_b    = signed'(MB'(thr_ff));
            state_in = S_STILL;
         end
         S_STILL: begin
            cnt_in   = cnt_new;
            sum_x_in = still_ok ? sum_x_sat : '0;
            sum_z_in = still_ok ? sum_z_sat : '0;
            state_in = fix_bias ? S_DIVX : S_CLUTCH;
         end
         S_DIVX: begin
            div_start = 1'b1;
            state_in  = S_WAITX;
         end
         S_WAITX: begin
            div_dividend = abs_z + half_cnt;
            if (div_res.done) begin
               bias_x_in = signed'(bias_x_full[BW-1:0]);
               div_start = 1'b1;
               state_in  = S_WAITZ;
            end
         end
         S_WAITZ: begin
            div_dividend = abs_z + half_cnt;
            if (div_res.done) begin
               bias_z_in = signed'(bias_z_full[BW-1:0]);
               cal_in    = 1'b1;
               state_in  = S_CLUTCH;
            end
         end
         S_CLUTCH: begin
            if (press) begin
               touch_start_in = time_ff;
            end
            clutch_in      = clutch_b;
            prior_touch_in = touch_ff;
            if (clear_motion) begin
               f_in[0]     = '0;
               f_in[1]     = '0;
               carry_in[0] = '0;
               carry_in[1] = '0;
            end
            dx_in    = '0;
            dy_in    = '0;
            axis_in  = 1'b0;
            state_in = run_axes ? S_AXF : S_DONE;
         end
         S_AXF: begin
            mul_a    = diff;
            mul_b    = signed'(MB'(alpha_eff));
            state_in = S_AXU;
         end
         S_AXU: begin
            f_in[axis_ff] = f_new;
            mul_a    = MA'(f_new);
            mul_b    = signed'(MB'(sens_ff));
            state_in = S_AXC;
         end
         S_AXC: begin
            carry_in[axis_ff] = carry_new;
            if (!axis_ff) begin
               dx_in    = step;
               axis_in  = 1'b1;
               state_in = S_AXF;
            end else begin
               dy_in    = step;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // result register frees up when its transfer completes
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_dx_in     = dx_ff;
               rsp_dy_in     = dy_ff;
               rsp_clutch_in = clutch_ff;
               rsp_cal_in    = cal_ff;
               rsp_send_in   = (clutch_ff == CLUTCH_ACTIVE) && link_ff &&
                               ((dx_ff != '0) || (dy_ff != '0));
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         sens_ff        <= SENS_RST;
         dz_ff          <= DZ_RST;
         alpha_ff       <= ALPHA_RST;
         thr_ff         <= THR_RST;
         calib_ff       <= CALIB_RST;
         hold_ff        <= HOLD_RST;
         cal_ff         <= 1'b0;
         cnt_ff         <= '0;
         sum_x_ff       <= '0;
         sum_z_ff       <= '0;
         bias_x_ff      <= '0;
         bias_z_ff      <= '0;
         clutch_ff      <= CLUTCH_IDLE;
         prior_touch_ff <= 1'b0;
         prior_link_ff  <= 1'b0;
         touch_start_ff <= '0;
         f_ff[0]        <= '0;
         f_ff[1]        <= '0;
         carry_ff[0]    <= '0;
         carry_ff[1]    <= '0;
         axis_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sens_ff        <= sens_in;
         dz_ff          <= dz_in;
         alpha_ff       <= alpha_in;
         thr_ff         <= thr_in;
         calib_ff       <= calib_in;
         hold_ff        <= hold_in;
         cal_ff         <= cal_in;
         cnt_ff         <= cnt_in;
         sum_x_ff       <= sum_x_in;
         sum_z_ff       <= sum_z_in;
         bias_x_ff      <= bias_x_in;
         bias_z_ff      <= bias_z_in;
         clutch_ff      <= clutch_in;
         prior_touch_ff <= prior_touch_in;
         prior_link_ff  <= prior_link_in;
         touch_start_ff <= touch_start_in;
         f_ff           <= f_in;
         carry_ff       <= carry_in;
         axis_ff        <= axis_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      gx_ff         <= gx_in;
      gy_ff         <= gy_in;
      gz_ff         <= gz_in;
      touch_ff      <= touch_in;
      link_ff       <= link_in;
      time_ff       <= time_in;
      mag_ff        <= mag_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      rsp_dx_ff     <= rsp_dx_in;
      rsp_dy_ff     <= rsp_dy_in;
      rsp_clutch_ff <= rsp_clutch_in;
      rsp_cal_ff    <= rsp_cal_in;
      rsp_send_ff   <= rsp_send_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_delta_x       = rsp_dx_ff;
   assign rsp_delta_y       = rsp_dy_ff;
   assign rsp_clutch        = rsp_clutch_ff;
   assign rsp_is_calibrated = rsp_cal_ff;
   assign rsp_send_report   = rsp_send_ff;

endmodule
